// ===== src/fpm_pkg.sv =====
// shared types and constants for the binary32 multiplier
`default_nettype none
package fpm_pkg;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG     = 31'h7F80_0000;
    localparam logic [7:0]  EXP_MAX     = 8'hFF;
    localparam int          EXP_BIAS    = 127;
    localparam int          PROD_SHIFT  = 46;

    typedef struct packed {
        logic        take;
        logic [31:0] bits;
    } special_t;
endpackage
`default_nettype wire

// ===== src/fpm_special.sv =====
// nan, infinity and zero detection with the fixed-result selection
`default_nettype none
module fpm_special
    import fpm_pkg::*;
(
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output special_t         special
);
    logic sign;
    logic a_max, b_max, a_frac, b_frac, a_ezero, b_ezero;
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    always_comb
    begin
        sign    = operand_a[31] ^ operand_b[31];
        a_max   = operand_a[30:23] == EXP_MAX;
        b_max   = operand_b[30:23] == EXP_MAX;
        a_ezero = operand_a[30:23] == 8'd0;
        b_ezero = operand_b[30:23] == 8'd0;
        a_frac  = operand_a[22:0] != 23'd0;
        b_frac  = operand_b[22:0] != 23'd0;
        a_nan   = a_max && a_frac;
        b_nan   = b_max && b_frac;
        a_inf   = a_max && !a_frac;
        b_inf   = b_max && !b_frac;
        a_zero  = a_ezero && !a_frac;
        b_zero  = b_ezero && !b_frac;
        special.take = 1'b1;
        if (a_nan)
            special.bits = operand_a;
        else if (b_nan)
            special.bits = operand_b;
        else if (a_inf)
            special.bits = b_zero ? DEFAULT_NAN : {sign, INF_MAG};
        else if (b_inf)
            special.bits = a_zero ? DEFAULT_NAN : {sign, INF_MAG};
        else if (a_zero || b_zero)
            special.bits = {sign, 31'd0};
        else
        begin
            special.take = 1'b0;
            special.bits = 32'd0;
        end
    end
endmodule
`default_nettype wire

// ===== src/fpm_datapath.sv =====
// significand multiply, normalize, denormalize and round to nearest even
`default_nettype none
module fpm_datapath
    import fpm_pkg::*;
(
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic      [31:0] product_bits
);
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    logic [47:0] prod, norm, shifted, lost_mask;
    logic [5:0]  lead, shamt;
    logic signed [10:0] e;
    logic [10:0] sh_full;
    logic [23:0] mant;
    logic [24:0] mant_r;
    logic        rnd, sticky, lost;
    logic [30:0] mag;

    always_comb
    begin
        ea   = (operand_a[30:23] == 8'd0) ? 8'd1 : operand_a[30:23];
        eb   = (operand_b[30:23] == 8'd0) ? 8'd1 : operand_b[30:23];
        ma   = {operand_a[30:23] != 8'd0, operand_a[22:0]};
        mb   = {operand_b[30:23] != 8'd0, operand_b[22:0]};
        prod = ma * mb;
        lead = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (prod[i])
                lead = 6'(i);
        end
        e = 11'(signed'({3'd0, ea})) + 11'(signed'({3'd0, eb}))
            + 11'(signed'({5'd0, lead})) - 11'(EXP_BIAS + PROD_SHIFT);
        norm = prod << (6'd47 - lead);
        sh_full = 11'(11'sd1 - e);
        shamt = (e > 0) ? 6'd0 : ((sh_full >= 11'd48) ? 6'd48 : sh_full[5:0]);
        shifted   = norm >> shamt;
        lost_mask = ~({48{1'b1}} << shamt);
        lost      = (norm & lost_mask) != 48'd0;
        mant   = shifted[47:24];
        rnd    = shifted[23];
        sticky = (shifted[22:0] != 23'd0) || lost;
        mant_r = {1'b0, mant} + 25'(rnd && (sticky || mant[0]));
        if (e >= 11'sd255)
            mag = INF_MAG;
        else if (e <= 11'sd0)
            mag = {6'd0, mant_r};
        else
        begin
            mag = ({e[7:0] - 8'd1, 23'd0}) + {6'd0, mant_r};
            if (mag[30:23] == EXP_MAX)
                mag = INF_MAG;
        end
        product_bits = {operand_a[31] ^ operand_b[31], mag};
    end
endmodule
`default_nettype wire

// ===== src/fp32_multiplier.sv =====
// top level of the binary32 multiplier with its two-register pipeline
// One product per clock unless the output stalls: operands are captured in an input
// register, special-case detection and the 24x24 significand multiply with normalize
// and round run in one pass, and the product is then registered in the result register.
// Back-pressure on the output stalls the whole pipe only when both registers are full.
`default_nettype none
module fp32_multiplier
    import fpm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [31:0] product_bits
);
    logic [31:0] a_reg, b_reg, prod_reg, prod_next, dp_bits;
    logic        s1_valid_reg, out_valid_reg, adv_out, adv_in;
    special_t    special;

    fpm_special u_special (.operand_a(a_reg), .operand_b(b_reg), .special(special));
    fpm_datapath u_datapath (.operand_a(a_reg), .operand_b(b_reg), .product_bits(dp_bits));

    always_comb
    begin
        adv_out   = !out_valid_reg || !out_stall;
        adv_in    = !s1_valid_reg || adv_out;
        in_stall  = !adv_in;
        prod_next = special.take ? special.bits : dp_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
                s1_valid_reg <= in_valid;
            if (adv_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (adv_out && s1_valid_reg)
            prod_reg <= prod_next;
    end

    assign out_valid    = out_valid_reg;
    assign product_bits = prod_reg;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipe");
    a_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !in_stall) |=> out_valid_reg)
        else $error("beat lost between stages");
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat not captured");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the binary32 multiplier with a scoreboard class
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import fpm_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_BEATS = 500;

    class product_scoreboard;
        logic [31:0] pending[$];
        int errors;
        int checked;

        function automatic logic [31:0] predict_product(logic [31:0] a, logic [31:0] b);
            logic        sgn;
            logic [7:0]  ea;
            logic [7:0]  eb;
            logic [23:0] ma;
            logic [23:0] mb;
            logic [63:0] prod;
            logic [63:0] lost;
            int          lead;
            int          e;
            int          sh;
            logic [31:0] mant;
            logic        rnd;
            logic        sticky;
            logic [31:0] bits;
            sgn = a[31] ^ b[31];
            ea = a[30:23];
            eb = b[30:23];
            ma = {1'b0, a[22:0]};
            mb = {1'b0, b[22:0]};
            if (ea == EXP_MAX && ma != 0)
                return a;
            if (eb == EXP_MAX && mb != 0)
                return b;
            if (ea == EXP_MAX)
                return (eb == 0 && mb == 0) ? DEFAULT_NAN : {sgn, INF_MAG};
            if (eb == EXP_MAX)
                return (ea == 0 && ma == 0) ? DEFAULT_NAN : {sgn, INF_MAG};
            if ((ea == 0 && ma == 0) || (eb == 0 && mb == 0))
                return {sgn, 31'd0};
            if (ea != 0) ma[23] = 1'b1; else ea = 8'd1;
            if (eb != 0) mb[23] = 1'b1; else eb = 8'd1;
            prod = 64'(ma) * 64'(mb);
            lead = 0;
            for (int i = 0; i < 64; i++)
                if (prod[i]) lead = i;
            e = int'(ea) + int'(eb) - EXP_BIAS + lead - PROD_SHIFT;
            prod = prod << (63 - lead);
            if (e >= 255)
                return {sgn, INF_MAG};
            if (e <= 0) begin
                sh = 1 - e;
                if (sh >= 64)
                    prod = (prod != 0) ? 64'd1 : 64'd0;
                else
                begin
                    lost = prod & ((64'd1 << sh) - 1);
                    prod = (prod >> sh) | ((lost != 0) ? 64'd1 : 64'd0);
                end
            end
            mant = 32'(prod >> 40);
            rnd = prod[39];
            sticky = prod[38:0] != 0;
            if (rnd && (sticky || mant[0]))
                mant++;
            if (e <= 0)
                return {sgn, 31'd0} | mant;
            bits = (32'(e - 1) << 23) + mant;
            if (bits[30:23] == EXP_MAX)
                bits = {1'b0, INF_MAG};
            return {sgn, bits[30:0]};
        endfunction

        function void note_operands(logic [31:0] a, logic [31:0] b);
            pending.push_back(predict_product(a, b));
        endfunction

        function void check_product(logic [31:0] got);
            logic [31:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected product %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: product_bits expected %h actual %h", $realtime, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] product_bits;

    product_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int directed_count = 0;

    always #5 clk = ~clk;

    fp32_multiplier u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .product_bits(product_bits)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_operands(operand_a, operand_b);
            if (out_valid && !out_stall)
                sb.check_product(product_bits);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $realtime, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_beat(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_products();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v[22:0] = 23'($urandom_range(3)) << $urandom_range(22);
            3: v[30:23] = 8'($urandom_range(40));
            4: v[30:23] = 8'($urandom_range(255, 215));
            default: v[30:23] = 8'($urandom_range(190, 64));
        endcase
        return v;
    endfunction

    logic [31:0] corner_vals[12] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0001, 32'hFF80_0001, 32'h0000_0001, 32'h807F_FFFF,
        32'h3F80_0000, 32'h7F7F_FFFF, 32'h0080_0000, 32'hBFFF_FFFF
    };

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 12; i++)
        begin
            send_beat(corner_vals[i], corner_vals[(i * 5 + 3) % 12]);
            directed_count++;
        end
        send_beat(32'h7F80_0000, 32'h8000_0000);
        send_beat(32'h7FA0_0000, 32'hFFC0_0001);
        send_beat(32'h3F80_0000, 32'h7F80_0001);
        send_beat(32'h7F00_0000, 32'h4000_0000);
        send_beat(32'h0080_0000, 32'h3F00_0000);
        send_beat(32'h0080_0000, 32'h3EFF_FFFF);
        send_beat(32'h0000_0001, 32'h3F00_0000);
        send_beat(32'h0000_0001, 32'h3F40_0000);
        send_beat(32'h3F80_0001, 32'h3F80_0001);
        send_beat(32'h7F7F_FFFF, 32'h3F80_0001);
        send_beat(32'hFFFF_FFFF, 32'h0000_0000);
        directed_count += 11;
        drain_products();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 48 : (ph == 3) ? 30 : 0;
            recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 30 : 0;
            for (int n = 0; n < RANDOM_BEATS / 4; n++)
                send_beat(random_float(), random_float());
            drain_products();
        end
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);

        $display("covered %0d directed and %0d random operand pairs, %0d products checked",
                 directed_count, RANDOM_BEATS, sb.checked);
        $display("idling phases: none, sender 48%%, receiver 48%%, both 30%%");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
